@@ rtl/assert_macros.svh @@
// assertion macros used by the top level rtl file
// expects i_clk and i_rst_n in the enclosing module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define GQLS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// condition must never be true out of reset
`define GQLS_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

@@ rtl/gqls_pkg.sv @@
// gridworld q-learning step: shared types, constants and helper functions
// no dependencies
package gqls_pkg;

    localparam int GRID_COLS   = 9;
    localparam int GRID_ROWS   = 6;
    localparam int Q_FRAC_BITS = 16;
    localparam int N_ACTIONS   = 4;
    localparam int N_CELLS     = GRID_ROWS * GRID_COLS;
    localparam int N_QENT      = N_CELLS * N_ACTIONS;
    localparam int CELL_AW     = $clog2(N_CELLS);
    localparam int Q_AW        = CELL_AW + 2;
    localparam int COL_W       = $clog2(GRID_COLS);
    localparam int CNT_W       = 3;
    localparam int Q_W         = 17;
    localparam int FRAC_W      = 17;
    localparam int FRAC_SH     = 16;
    localparam int MUL_A_W     = 17;
    localparam int MUL_B_W     = 18;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int ACC_W       = PROD_W + 1;

    localparam logic [Q_W-1:0]    Q_ONE    = Q_W'(1) << Q_FRAC_BITS;
    localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);
    localparam logic [CNT_W-1:0]  CNT_END  = CNT_W'(N_ACTIONS);

    typedef enum logic [1:0] {
        OP_STEP  = 2'd0,
        OP_WALL  = 2'd1,
        OP_QREAD = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ACT_RIGHT = 2'd0,
        ACT_DOWN  = 2'd1,
        ACT_LEFT  = 2'd2,
        ACT_UP    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        CFG_LEARN_RATE   = 2'd0,
        CFG_DISCOUNT     = 2'd1,
        CFG_EXPLORE_RATE = 2'd2,
        CFG_GOAL_STATE   = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EMIT,
        ST_QWAIT,
        ST_ROW,
        ST_CHOOSE,
        ST_WALL,
        ST_NROW,
        ST_MUL_G,
        ST_MUL_O,
        ST_MUL_T,
        ST_MUL_A,
        ST_ACC,
        ST_WB
    } t_state;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  state;
        logic [1:0]  action_index;
        logic        wall_value;
        logic [15:0] rand_explore;
        logic [1:0]  rand_action;
        logic [3:0]  rand_tie;
    } t_item;

    typedef struct packed {
        logic [1:0]     chosen_action;
        logic [7:0]     next_state;
        logic           reward;
        logic [Q_W-1:0] q_value;
        logic           goal_reached;
    } t_result;

    typedef struct packed {
        logic acc_load;
        logic acc_add;
    } t_mac_ctl;

    // column of a cell index on the grid
    function automatic logic [COL_W-1:0] cell_col(input logic [7:0] s);
        logic [COL_W-1:0] col;
        col = '0;
        for (int r = 0; r < GRID_ROWS; r++) begin
            if ({1'b0, s} >= 9'(r * GRID_COLS)) begin
                col = COL_W'({1'b0, s} - 9'(r * GRID_COLS));
            end
        end
        return col;
    endfunction

    // tied action number (tie mod count) among the set bits of mask
    function automatic logic [1:0] tie_pick(input logic [3:0] mask, input logic [3:0] tie);
        logic [2:0] cnt;
        logic [3:0] rem;
        logic [2:0] seen;
        logic [1:0] pick;
        logic       found;
        cnt = '0;
        for (int a = 0; a < 4; a++) begin
            cnt = cnt + 3'(mask[a]);
        end
        case (cnt)
            3'd2: rem = {3'b000, tie[0]};
            3'd3: begin
                rem = tie;
                for (int i = 0; i < 5; i++) begin
                    if (rem >= 4'd3) begin
                        rem = rem - 4'd3;
                    end
                end
            end
            3'd4: rem = {2'b00, tie[1:0]};
            default: rem = '0;
        endcase
        pick  = '0;
        seen  = '0;
        found = 1'b0;
        for (int a = 0; a < 4; a++) begin
            if (mask[a] && !found) begin
                if (seen == rem[2:0]) begin
                    pick  = 2'(a);
                    found = 1'b1;
                end
                seen = seen + 3'd1;
            end
        end
        return pick;
    endfunction

endpackage

@@ rtl/gridworld_q_learning_step.sv @@
// top level of the gridworld q-learning step: sequencer, q table and wall map
// depends on gqls_pkg, gqls_ram, gqls_mac and assert_macros.svh
//
// A word is taken when start is high and busy is low; busy stays high until the
// result is ready, and the result strobe o_result_valid rises at the edge where busy
// falls and stays high for exactly one cycle, with no way for the receiver to stall it.
// In an agent step the eight q table reads go one per cycle through the table's
// single read port in two passes, ST_ROW for the current row and ST_NROW for the
// next state's row, with action choice and wall lookup (ST_CHOOSE, ST_WALL) between
// them; the update then runs in ST_MUL_G to ST_WB on the one shared 17x18 multiplier.
// A wall write, an operation three, a q read or a step from a state off the grid is
// busy only in ST_EMIT or ST_QWAIT. The q table and wall map need no clearing pass after reset.
`include "assert_macros.svh"

module gridworld_q_learning_step
    import gqls_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_item       i_item,
    output logic        o_result_valid,
    output t_result     o_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data
);

    t_state r_state, n_state;

    logic [FRAC_W-1:0] r_learn_rate, r_discount, r_explore_rate;
    logic [7:0]        r_goal;

    t_item            r_item;
    t_result          r_res;
    logic             r_res_vld;
    logic [CNT_W-1:0] r_cnt;
    logic             r_rd_vld;
    logic [1:0]       r_rd_idx;
    logic [Q_W-1:0]   r_q_row [N_ACTIONS];
    logic [Q_W-1:0]   r_max;
    logic [1:0]       r_act;
    logic [7:0]       r_tgt;
    logic             r_ok;
    logic [7:0]       r_nxt;
    logic             r_rew;
    logic [MUL_B_W-1:0] r_t;

    logic             accept;
    logic             in_valid;
    logic             rd_issue;
    logic [FRAC_W-1:0] alpha_c, gamma_c;

    logic             q_we;
    logic [Q_AW-1:0]  q_waddr, q_raddr;
    logic [Q_W-1:0]   q_wdata, q_rdata;
    logic             w_we;
    logic [CELL_AW-1:0] w_waddr, w_raddr;
    logic             w_wdata, w_rdata;

    t_mac_ctl           mac_ctl;
    logic [MUL_A_W-1:0] mac_a;
    logic [MUL_B_W-1:0] mac_b;
    logic [ACC_W-1:0]   mac_acc;

    logic [3:0]       tie_mask;
    logic             greedy;
    logic [1:0]       act_sel;
    logic [COL_W-1:0] col;
    logic [8:0]       s9, tgt9;
    logic             tgt_ok;
    logic [7:0]       nxt;
    logic [ACC_W-FRAC_SH-1:0] acc_hi;
    logic [Q_W-1:0]   nq;

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign accept      = start && !busy;
    assign in_valid    = ({1'b0, i_item.state} < 9'(N_CELLS));

    assign alpha_c = (r_learn_rate > FRAC_ONE) ? FRAC_ONE : r_learn_rate;
    assign gamma_c = (r_discount > FRAC_ONE) ? FRAC_ONE : r_discount;

    // action choice and move
    always_comb begin
        for (int a = 0; a < N_ACTIONS; a++) begin
            tie_mask[a] = (r_q_row[a] == r_max);
        end
        greedy  = ({1'b0, r_item.rand_explore} > r_explore_rate);
        act_sel = greedy ? tie_pick(tie_mask, r_item.rand_tie) : r_item.rand_action;
        s9      = {1'b0, r_item.state};
        col     = cell_col(r_item.state);
        case (t_action'(act_sel))
            ACT_RIGHT: begin
                tgt9   = s9 + 9'd1;
                tgt_ok = (col != COL_W'(GRID_COLS - 1));
            end
            ACT_DOWN: begin
                tgt9   = s9 + 9'(GRID_COLS);
                tgt_ok = (tgt9 < 9'(N_CELLS));
            end
            ACT_LEFT: begin
                tgt9   = s9 - 9'd1;
                tgt_ok = (col != '0);
            end
            ACT_UP: begin
                tgt9   = s9 - 9'(GRID_COLS);
                tgt_ok = (s9 >= 9'(GRID_COLS));
            end
            default: begin
                tgt9   = s9;
                tgt_ok = 1'b0;
            end
        endcase
        nxt    = (r_ok && !w_rdata) ? r_tgt : r_item.state;
        acc_hi = mac_acc[ACC_W-1:FRAC_SH];
        nq     = (acc_hi > (ACC_W-FRAC_SH)'(Q_ONE)) ? Q_ONE : acc_hi[Q_W-1:0];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_item.operation == OP_STEP && in_valid) begin
                        n_state = ST_ROW;
                    end else if (i_item.operation == OP_QREAD && in_valid) begin
                        n_state = ST_QWAIT;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT:   n_state = ST_IDLE;
            ST_QWAIT:  n_state = ST_IDLE;
            ST_ROW:    n_state = (r_cnt == CNT_END) ? ST_CHOOSE : ST_ROW;
            ST_CHOOSE: n_state = ST_WALL;
            ST_WALL:   n_state = ST_NROW;
            ST_NROW:   n_state = (r_cnt == CNT_END) ? ST_MUL_G : ST_NROW;
            ST_MUL_G:  n_state = ST_MUL_O;
            ST_MUL_O:  n_state = ST_MUL_T;
            ST_MUL_T:  n_state = ST_MUL_A;
            ST_MUL_A:  n_state = ST_ACC;
            ST_ACC:    n_state = ST_WB;
            ST_WB:     n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // memory and multiplier controls
    always_comb begin
        q_we     = 1'b0;
        q_waddr  = {r_item.state[CELL_AW-1:0], r_act};
        q_wdata  = nq;
        q_raddr  = {r_item.state[CELL_AW-1:0], r_cnt[1:0]};
        w_we     = 1'b0;
        w_waddr  = i_item.state[CELL_AW-1:0];
        w_wdata  = i_item.wall_value;
        w_raddr  = tgt9[CELL_AW-1:0];
        rd_issue = 1'b0;
        mac_ctl  = '0;
        mac_a    = gamma_c;
        mac_b    = MUL_B_W'(r_max);
        case (r_state)
            ST_IDLE: begin
                q_raddr = {i_item.state[CELL_AW-1:0], i_item.action_index};
                w_we    = accept && (i_item.operation == OP_WALL) && in_valid;
            end
            ST_ROW: begin
                rd_issue = (r_cnt != CNT_END);
            end
            ST_NROW: begin
                q_raddr  = {r_nxt[CELL_AW-1:0], r_cnt[1:0]};
                rd_issue = (r_cnt != CNT_END);
            end
            ST_MUL_O: begin
                mac_a            = r_q_row[r_act];
                mac_b            = {1'b0, FRAC_ONE - alpha_c};
                mac_ctl.acc_load = 1'b1;
            end
            ST_MUL_T: begin
                mac_ctl.acc_load = 1'b1;
            end
            ST_MUL_A: begin
                mac_a = alpha_c;
                mac_b = r_t;
            end
            ST_ACC: begin
                mac_ctl.acc_add = 1'b1;
            end
            ST_WB: begin
                q_we = 1'b1;
            end
            default: begin
                q_we = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_cnt          <= '0;
            r_rd_vld       <= 1'b0;
            r_res_vld      <= 1'b0;
            r_learn_rate   <= FRAC_W'(6554);
            r_discount     <= FRAC_W'(62259);
            r_explore_rate <= FRAC_W'(6554);
            r_goal         <= 8'd8;
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= rd_issue;
            r_res_vld <= (r_state == ST_EMIT) || (r_state == ST_QWAIT) || (r_state == ST_WB);
            if (r_state == ST_ROW || r_state == ST_NROW) begin
                r_cnt <= (r_cnt == CNT_END) ? '0 : r_cnt + CNT_W'(1);
            end else begin
                r_cnt <= '0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_LEARN_RATE:   r_learn_rate   <= i_cfg_data;
                    CFG_DISCOUNT:     r_discount     <= i_cfg_data;
                    CFG_EXPLORE_RATE: r_explore_rate <= i_cfg_data;
                    CFG_GOAL_STATE:   r_goal         <= i_cfg_data[7:0];
                    default:          r_goal         <= r_goal;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_cnt[1:0];
        if (r_rd_vld) begin
            if (q_rdata > r_max) begin
                r_max <= q_rdata;
            end
            if (r_state == ST_ROW) begin
                r_q_row[r_rd_idx] <= q_rdata;
            end
        end
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_item <= i_item;
                    r_max  <= '0;
                    r_res  <= '{chosen_action: 2'd0,
                                next_state: (i_item.operation == OP_STEP && !in_valid) ?
                                            i_item.state : 8'd0,
                                reward: 1'b0,
                                q_value: Q_W'(0),
                                goal_reached: 1'b0};
                end
            end
            ST_QWAIT: begin
                r_res.q_value <= q_rdata;
            end
            ST_CHOOSE: begin
                r_act <= act_sel;
                r_tgt <= tgt9[7:0];
                r_ok  <= tgt_ok;
            end
            ST_WALL: begin
                r_nxt <= nxt;
                r_rew <= (nxt == r_goal);
                r_max <= '0;
            end
            ST_MUL_T: begin
                r_t <= (r_rew ? MUL_B_W'(Q_ONE) : '0) + mac_acc[FRAC_SH+MUL_B_W-1:FRAC_SH];
            end
            ST_WB: begin
                r_res <= '{chosen_action: r_act,
                           next_state: r_nxt,
                           reward: r_rew,
                           q_value: nq,
                           goal_reached: r_rew};
            end
            default: begin
                r_t <= r_t;
            end
        endcase
    end

    assign o_result_valid = r_res_vld;
    assign o_result       = r_res;

    gqls_ram #(
        .DEPTH (N_QENT),
        .WIDTH (Q_W)
    ) u_q_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );

    gqls_ram #(
        .DEPTH (N_CELLS),
        .WIDTH (1)
    ) u_wall_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    gqls_mac u_mac (
        .i_clk (i_clk),
        .i_a   (mac_a),
        .i_b   (mac_b),
        .i_ctl (mac_ctl),
        .o_acc (mac_acc)
    );

    `GQLS_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted word did not raise busy")
    `GQLS_ASSERT(a_strobe_after_busy, o_result_valid |-> $past(busy), "result without work")
    `GQLS_ASSERT(a_strobe_gap, o_result_valid |=> !o_result_valid, "back to back result strobe")
    `GQLS_NEVER(a_q_sat, q_we && (q_wdata > Q_ONE), "q table write above one")

endmodule

@@ rtl/gqls_ram.sv @@
// single write, single registered read ram with per-entry valid bits
// unwritten entries read as zero after reset; uses no package
module gqls_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [WIDTH-1:0] r_rd_data;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd_data <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_rd_vld ? r_rd_data : '0;

endmodule

@@ rtl/gqls_mac.sv @@
// shared multiply-accumulate unit: registered product, then accumulator
// depends on gqls_pkg
module gqls_mac
    import gqls_pkg::*;
(
    input  logic               i_clk,
    input  logic [MUL_A_W-1:0] i_a,
    input  logic [MUL_B_W-1:0] i_b,
    input  t_mac_ctl           i_ctl,
    output logic [ACC_W-1:0]   o_acc
);

    logic [PROD_W-1:0] r_prod;
    logic [ACC_W-1:0]  r_acc;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
        if (i_ctl.acc_load) begin
            r_acc <= ACC_W'(r_prod);
        end else if (i_ctl.acc_add) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign o_acc = r_acc;

endmodule

@@ dv/gqls_step_check.sv @@
// checker for gridworld_q_learning_step: watches the command, result and config channels
// keeps its own q table, wall map and registers, predicts each result word and compares
// depends on gqls_pkg
module gqls_step_check
    import gqls_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  t_item       i_item,
    input  logic        i_result_valid,
    input  t_result     i_result,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned ONE_Q  = 64'd1 << Q_FRAC_BITS;
    localparam longint unsigned UNIT_F = 64'd65536;

    logic [Q_W-1:0] q_tab [N_QENT];
    logic           wall_map [N_CELLS];
    logic [16:0]    learn_r;
    logic [16:0]    discount_r;
    logic [16:0]    explore_r;
    logic [7:0]     goal_r;

    t_result        pending_results [$];
    t_result        want;
    int             err_count = 0;

    task automatic clear_model();
        for (int i = 0; i < N_QENT; i++) begin
            q_tab[i] = '0;
        end
        for (int i = 0; i < N_CELLS; i++) begin
            wall_map[i] = 1'b0;
        end
        learn_r    = 17'd6554;
        discount_r = 17'd62259;
        explore_r  = 17'd6554;
        goal_r     = 8'd8;
    endtask

    function automatic longint unsigned clamp_unit(input logic [16:0] v);
        return (v > 17'd65536) ? UNIT_F : longint'(v);
    endfunction

    function automatic longint unsigned row_best(input int unsigned s);
        longint unsigned m;
        m = 0;
        for (int a = 0; a < N_ACTIONS; a++) begin
            if (q_tab[s * N_ACTIONS + a] > m) begin
                m = q_tab[s * N_ACTIONS + a];
            end
        end
        return m;
    endfunction

    // applies one command word to the model and returns the result word it causes
    function automatic t_result compute_result(input t_item w);
        t_result         r;
        t_action         act;
        int unsigned     s, nxt, tgt_idx, row, col, cnt, pick, seen;
        bit              moved, rew;
        longint unsigned best, alpha, old, tgt, num, nq;
        r = '0;
        s = w.state;
        case (t_op'(w.operation))
            OP_WALL: begin
                if (s < N_CELLS) begin
                    wall_map[s] = w.wall_value;
                end
            end
            OP_QREAD: begin
                if (s < N_CELLS) begin
                    r.q_value = q_tab[s * N_ACTIONS + w.action_index];
                end
            end
            OP_STEP: begin
                if (s >= N_CELLS) begin
                    r.next_state = w.state;
                end else begin
                    if ({1'b0, w.rand_explore} > explore_r) begin
                        best = row_best(s);
                        cnt  = 0;
                        for (int a = 0; a < N_ACTIONS; a++) begin
                            if (q_tab[s * N_ACTIONS + a] == best) begin
                                cnt++;
                            end
                        end
                        pick = w.rand_tie % cnt;
                        seen = 0;
                        act  = ACT_RIGHT;
                        for (int a = N_ACTIONS - 1; a >= 0; a--) begin
                            if (q_tab[s * N_ACTIONS + a] == best) begin
                                if (cnt - 1 - seen == pick) begin
                                    act = t_action'(a);
                                end
                                seen++;
                            end
                        end
                    end else begin
                        act = t_action'(w.rand_action);
                    end
                    row     = s / GRID_COLS;
                    col     = s % GRID_COLS;
                    moved   = 1'b0;
                    tgt_idx = s;
                    case (act)
                        ACT_RIGHT: if (col + 1 < GRID_COLS) begin
                            tgt_idx = s + 1;
                            moved   = 1'b1;
                        end
                        ACT_DOWN: if (row + 1 < GRID_ROWS) begin
                            tgt_idx = s + GRID_COLS;
                            moved   = 1'b1;
                        end
                        ACT_LEFT: if (col > 0) begin
                            tgt_idx = s - 1;
                            moved   = 1'b1;
                        end
                        ACT_UP: if (row > 0) begin
                            tgt_idx = s - GRID_COLS;
                            moved   = 1'b1;
                        end
                        default: ;
                    endcase
                    nxt   = (moved && !wall_map[tgt_idx]) ? tgt_idx : s;
                    rew   = (nxt == goal_r);
                    alpha = clamp_unit(learn_r);
                    old   = q_tab[s * N_ACTIONS + act];
                    tgt   = (rew ? ONE_Q : 0) + ((clamp_unit(discount_r) * row_best(nxt)) >> 16);
                    num   = old * (UNIT_F - alpha) + alpha * tgt;
                    nq    = num >> 16;
                    if (nq > ONE_Q) begin
                        nq = ONE_Q;
                    end
                    q_tab[s * N_ACTIONS + act] = Q_W'(nq);
                    r.chosen_action = act;
                    r.next_state    = 8'(nxt);
                    r.reward        = rew;
                    r.q_value       = Q_W'(nq);
                    r.goal_reached  = rew;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic check_field(input string field, input logic [16:0] exp_v,
                               input logic [16:0] act_v);
        if (exp_v !== act_v) begin
            err_count++;
            $display("%0t gqls_step_check: %s expected %0d got %0d", $time, field, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_model();
            pending_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_LEARN_RATE:   learn_r    = i_cfg_data;
                    CFG_DISCOUNT:     discount_r = i_cfg_data;
                    CFG_EXPLORE_RATE: explore_r  = i_cfg_data;
                    CFG_GOAL_STATE:   goal_r     = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_result_valid) begin
                if (pending_results.size() == 0) begin
                    err_count++;
                    $display("%0t gqls_step_check: expected no word got %h", $time, i_result);
                end else begin
                    want = pending_results.pop_front();
                    check_field("chosen_action", want.chosen_action, i_result.chosen_action);
                    check_field("next_state", want.next_state, i_result.next_state);
                    check_field("reward", want.reward, i_result.reward);
                    check_field("q_value", want.q_value, i_result.q_value);
                    check_field("goal_reached", want.goal_reached, i_result.goal_reached);
                end
            end
            if (i_start && !i_busy) begin
                pending_results.push_back(compute_result(i_item));
            end
        end
        o_pending = pending_results.size();
        o_errors  = err_count;
    end

endmodule

@@ dv/tb.sv @@
// testbench top for gridworld_q_learning_step: clock, reset, command and config stimulus
// directed words, then random phases over several register settings; verdict from gqls_step_check
// depends on gqls_pkg, gqls_step_check and the rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import gqls_pkg::*;

    localparam int N_RANDOM    = 800;
    localparam int N_PHASES    = 5;
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_item       i_item;
    logic        o_result_valid;
    t_result     o_result;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    t_cfg_idx    i_cfg_index;
    logic [16:0] i_cfg_data;

    int          errors;
    int          pending;
    int          cycles = 0;
    logic [7:0]  goal_cell;
    bit          gaps_on;

    logic [16:0] alpha_set [N_PHASES] = '{17'd65536, 17'd131071, 17'd0, 17'd32768, 17'd0};
    logic [16:0] gamma_set [N_PHASES] = '{17'd62259, 17'd131071, 17'd0, 17'd65535, 17'd0};
    logic [16:0] eps_set   [N_PHASES] = '{17'd6554, 17'd0, 17'd131071, 17'd20000, 17'd0};
    logic [7:0]  goal_set  [N_PHASES] = '{8'd8, 8'd53, 8'd0, 8'd255, 8'd0};

    gridworld_q_learning_step dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    gqls_step_check u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_item         (i_item),
        .i_result_valid (o_result_valid),
        .i_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_errors       (errors),
        .o_pending      (pending)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    function automatic t_item mk(input t_op op, input logic [7:0] s, input logic [1:0] ai,
                                 input logic wv, input logic [15:0] rexp,
                                 input logic [1:0] ract, input logic [3:0] rtie);
        t_item w;
        w.operation    = op;
        w.state        = s;
        w.action_index = ai;
        w.wall_value   = wv;
        w.rand_explore = rexp;
        w.rand_action  = ract;
        w.rand_tie     = rtie;
        return w;
    endfunction

    // mostly agent steps around the goal so that q values build up and ties break
    function automatic t_item random_word();
        t_item       w;
        int unsigned pick, r, c;
        w = mk(OP_STEP, 8'd0, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
               16'($urandom_range(0, 65535)), 2'($urandom_range(0, 3)),
               4'($urandom_range(0, 15)));
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            w.operation  = OP_WALL;
            w.wall_value = ($urandom_range(0, 99) < 40);
        end else if (pick < 14) begin
            w.operation = OP_QREAD;
        end else if (pick < 16) begin
            w.operation = OP_NONE;
        end
        if ($urandom_range(0, 9) == 0) begin
            w.rand_explore = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
        end
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            w.state = 8'($urandom_range(0, 255));
        end else if (pick < 30 || goal_cell >= N_CELLS) begin
            w.state = 8'($urandom_range(0, N_CELLS - 1));
        end else begin
            r = goal_cell / GRID_COLS + $urandom_range(0, 4);
            c = goal_cell % GRID_COLS + $urandom_range(0, 4);
            r = (r < 2) ? 0 : r - 2;
            c = (c < 2) ? 0 : c - 2;
            if (r > GRID_ROWS - 1) r = GRID_ROWS - 1;
            if (c > GRID_COLS - 1) c = GRID_COLS - 1;
            w.state = 8'(r * GRID_COLS + c);
        end
        return w;
    endfunction

    task automatic send_word(input t_item w);
        if (gaps_on && $urandom_range(0, 99) < 35) begin
            start = 1'b0;
            repeat ($urandom_range(1, 24)) @(negedge i_clk);
        end
        start  = 1'b1;
        i_item = w;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    task automatic drain();
        start = 1'b0;
        while (pending != 0 || busy) @(negedge i_clk);
    endtask

    task automatic write_regs(input logic [16:0] alpha, input logic [16:0] gamma,
                              input logic [16:0] eps, input logic [7:0] goal);
        for (int k = 0; k < 4; k++) begin
            i_cfg_valid = 1'b1;
            i_cfg_index = t_cfg_idx'(k);
            case (t_cfg_idx'(k))
                CFG_LEARN_RATE:   i_cfg_data = alpha;
                CFG_DISCOUNT:     i_cfg_data = gamma;
                CFG_EXPLORE_RATE: i_cfg_data = eps;
                CFG_GOAL_STATE:   i_cfg_data = {9'd0, goal};
                default:          i_cfg_data = '0;
            endcase
            do @(posedge i_clk); while (!o_cfg_ready);
            @(negedge i_clk);
        end
        i_cfg_valid = 1'b0;
        goal_cell   = goal;
    endtask

    initial begin
        start       = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_LEARN_RATE;
        i_cfg_data  = '0;
        i_rst_n     = 1'b0;
        goal_cell   = 8'd8;
        gaps_on     = 1'b1;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // reset register values: explore at or below 6554, goal in cell 8
        send_word(mk(OP_QREAD, 8'd0, ACT_RIGHT, 1'b0, 16'd0, ACT_RIGHT, 4'd0));
        send_word(mk(OP_WALL, 8'd1, ACT_RIGHT, 1'b1, 16'd0, ACT_RIGHT, 4'd0));
        send_word(mk(OP_STEP, 8'd0, ACT_RIGHT, 1'b0, 16'd0, ACT_RIGHT, 4'd0));
        send_word(mk(OP_STEP, 8'd0, ACT_RIGHT, 1'b0, 16'd6554, ACT_DOWN, 4'd0));
        send_word(mk(OP_STEP, 8'd0, ACT_RIGHT, 1'b0, 16'd100, ACT_LEFT, 4'd0));
        send_word(mk(OP_STEP, 8'd0, ACT_RIGHT, 1'b0, 16'd100, ACT_UP, 4'd0));
        send_word(mk(OP_STEP, 8'd1, ACT_RIGHT, 1'b0, 16'd0, ACT_DOWN, 4'd0));
        send_word(mk(OP_STEP, 8'd7, ACT_RIGHT, 1'b0, 16'd0, ACT_RIGHT, 4'd0));
        send_word(mk(OP_STEP, 8'd8, ACT_RIGHT, 1'b0, 16'd0, ACT_RIGHT, 4'd0));
        send_word(mk(OP_STEP, 8'd8, ACT_RIGHT, 1'b0, 16'd0, ACT_UP, 4'd0));
        send_word(mk(OP_STEP, 8'd7, ACT_RIGHT, 1'b0, 16'hffff, ACT_LEFT, 4'd15));
        send_word(mk(OP_STEP, 8'd0, ACT_RIGHT, 1'b0, 16'd6555, ACT_LEFT, 4'd0));
        send_word(mk(OP_STEP, 8'd10, ACT_RIGHT, 1'b0, 16'hffff, ACT_RIGHT, 4'd11));
        send_word(mk(OP_STEP, 8'd53, ACT_RIGHT, 1'b0, 16'd0, ACT_RIGHT, 4'd0));
        send_word(mk(OP_STEP, 8'd53, ACT_RIGHT, 1'b0, 16'd0, ACT_DOWN, 4'd0));
        send_word(mk(OP_STEP, 8'd54, ACT_UP, 1'b1, 16'hffff, ACT_UP, 4'd15));
        send_word(mk(OP_STEP, 8'd255, ACT_UP, 1'b1, 16'd0, ACT_UP, 4'd15));
        send_word(mk(OP_QREAD, 8'd7, ACT_RIGHT, 1'b0, 16'd0, ACT_RIGHT, 4'd0));
        send_word(mk(OP_QREAD, 8'd255, ACT_UP, 1'b1, 16'hffff, ACT_UP, 4'd15));
        send_word(mk(OP_QREAD, 8'd54, ACT_LEFT, 1'b0, 16'd0, ACT_RIGHT, 4'd0));
        send_word(mk(OP_NONE, 8'd5, ACT_UP, 1'b1, 16'hffff, ACT_UP, 4'd15));
        send_word(mk(OP_WALL, 8'd255, ACT_RIGHT, 1'b1, 16'd0, ACT_RIGHT, 4'd0));
        send_word(mk(OP_WALL, 8'd1, ACT_RIGHT, 1'b0, 16'd0, ACT_RIGHT, 4'd0));
        send_word(mk(OP_STEP, 8'd0, ACT_RIGHT, 1'b0, 16'd0, ACT_RIGHT, 4'd0));
        send_word(mk(OP_STEP, 8'd8, ACT_RIGHT, 1'b0, 16'hffff, ACT_RIGHT, 4'd5));
        drain();

        alpha_set[N_PHASES-1] = 17'($urandom_range(0, 131071));
        gamma_set[N_PHASES-1] = 17'($urandom_range(0, 131071));
        eps_set[N_PHASES-1]   = 17'($urandom_range(0, 131071));
        goal_set[N_PHASES-1]  = 8'($urandom_range(0, N_CELLS + 6));
        for (int p = 0; p < N_PHASES; p++) begin
            write_regs(alpha_set[p], gamma_set[p], eps_set[p], goal_set[p]);
            gaps_on = (p != 1);
            repeat (N_RANDOM / N_PHASES) send_word(random_word());
            drain();
        end

        repeat (30) @(negedge i_clk);
        if (errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/gqls_pkg.sv
rtl/gqls_ram.sv
rtl/gqls_mac.sv
rtl/gridworld_q_learning_step.sv
dv/gqls_step_check.sv
dv/tb.sv
